### sv/sfd_pkg.sv
// Shared constants, types and tables of the facilitation/depression synapse updater.
package sfd_pkg;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_IDX_W  = 4;
  localparam int EL_W       = 21;
  localparam int DIV_STAGES = 64;

  localparam logic [31:0] ONE_Q16     = 32'd65536;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [31:0] MAX_ELAPSED = 32'd1048576;
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [16:0] SAT17       = 17'h1_FFFF;

  // rule modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_FAC_DEP = 2'd1;
  localparam logic [1:0] MODE_DEP_DEP = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAC_INC    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEP1_SCALE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEP2_SCALE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAC_RATE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEP1_RATE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEP2_RATE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 4'd7;

  // record carried alongside the divider
  typedef struct packed {
    logic        do_upd;
    logic        pzero;
    logic [31:0] ao;
    logic [16:0] bo;
    logic [48:0] prod;
    logic [31:0] w;
    logic [31:0] a;
    logic [16:0] b;
    logic [31:0] upd;
    logic        uv;
    logic        fin;
  } div_side_t;

  // 2^(-2^-(idx+1)) in Q0.32, rounded
  function automatic logic [31:0] pow2_neg_frac(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'd3037000500;
      3'd1:    c = 32'd3611622603;
      3'd2:    c = 32'd3938502376;
      3'd3:    c = 32'd4112874773;
      3'd4:    c = 32'd4202935003;
      3'd5:    c = 32'd4248741818;
      3'd6:    c = 32'd4271808726;
      default: c = 32'd4283353945;
    endcase
    return c;
  endfunction

endpackage

### sv/sfd_exp.sv
// Pipelined exp(-elapsed*rate) in Q1.32.
module sfd_exp #(
  parameter int TBITS = 4
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [sfd_pkg::EL_W-1:0] elapsed,
  input  logic [23:0]              rate,
  output logic [32:0]              e_out
);
  import sfd_pkg::*;

  localparam int RBITS = 24 - TBITS;
  localparam int LBITS = 32 - TBITS;
  localparam int LMW   = RBITS + 32;
  localparam int MLW   = 33 + LBITS;

  logic [44:0]       x_r;
  logic              big_r;
  logic [30:0]       y_r;
  logic [32:0]       m_r   [TBITS+1];
  logic [4:0]        k_r   [TBITS+1];
  logic [TBITS-1:0]  top_r [TBITS+1];
  logic [LBITS-1:0]  lin_r [TBITS+1];
  logic              zero_r[TBITS+1];
  logic [32:0]       m_nxt [1:TBITS];
  logic [LBITS-1:0]  t_r;
  logic [32:0]       m1_r;
  logic [4:0]        k1_r;
  logic              z1_r;
  logic [32:0]       e_r;

  logic [60:0]       ym;
  logic [LMW-1:0]    lm;
  logic [MLW-1:0]    mlin;
  logic [32:0]       m2;

  assign ym   = 61'(x_r[29:0]) * 61'(LOG2E_Q30);
  assign lm   = LMW'(y_r[RBITS-1:0]) * LMW'(LN2_Q32);
  assign mlin = MLW'(m_r[TBITS]) * MLW'(lin_r[TBITS]);
  assign m2   = m1_r - 33'(t_r);

  // one table multiply per stage, applied where the fraction bit is set
  always_comb begin
    logic [64:0] prod;
    prod = '0;
    for (int j = 1; j <= TBITS; j++) begin
      prod = 65'(m_r[j-1]) * 65'(pow2_neg_frac(3'(j-1))) + 65'h8000_0000;
      m_nxt[j] = top_r[j-1][TBITS-j] ? prod[64:32] : m_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= 45'(elapsed) * 45'(rate);
      big_r <= |x_r[44:30];
      y_r   <= ym[60:30];
      zero_r[0] <= big_r | (|y_r[30:29]);
      k_r[0]    <= y_r[28:24];
      top_r[0]  <= y_r[23:24-TBITS];
      lin_r[0]  <= lm[LMW-1:24];
      m_r[0]    <= 33'h1_0000_0000;
      for (int j = 1; j <= TBITS; j++) begin
        m_r[j]    <= m_nxt[j];
        k_r[j]    <= k_r[j-1];
        top_r[j]  <= top_r[j-1];
        lin_r[j]  <= lin_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
      t_r  <= mlin[32+LBITS-1:32];
      m1_r <= m_r[TBITS];
      k1_r <= k_r[TBITS];
      z1_r <= zero_r[TBITS];
      e_r  <= z1_r ? 33'd0 : (m2 >> k1_r);
    end
  end

  assign e_out = e_r;

endmodule

### sv/sfd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side record.
module sfd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [63:0]        dividend,
  input  logic [48:0]        divisor,
  input  sfd_pkg::div_side_t side_in,
  output logic               out_vld,
  output logic [63:0]        quotient,
  output sfd_pkg::div_side_t side_out
);
  import sfd_pkg::*;

  localparam int N = DIV_STAGES;

  logic [N-1:0] vld_r;
  logic [48:0]  rem_r  [N];
  logic [63:0]  rq_r   [N];
  logic [48:0]  dvs_r  [N];
  div_side_t    side_r [N];
  logic [48:0]  rem_nxt[N];
  logic [63:0]  rq_nxt [N];

  // shift in the next dividend bit, subtract when it fits, shift in the quotient bit
  function automatic logic [112:0] div_step(input logic [48:0] rem, input logic [63:0] rq,
                                            input logic [48:0] dvs);
    logic [49:0] t;
    logic [49:0] d;
    logic        ge;
    t  = {rem, rq[63]};
    d  = {1'b0, dvs};
    ge = (t >= d);
    return {ge ? 49'(t - d) : t[48:0], rq[62:0], ge};
  endfunction

  always_comb begin
    {rem_nxt[0], rq_nxt[0]} = div_step(49'd0, dividend, divisor);
    for (int i = 1; i < N; i++) begin
      {rem_nxt[i], rq_nxt[i]} = div_step(rem_r[i-1], rq_r[i-1], dvs_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r[0]  <= divisor;
      side_r[0] <= side_in;
      for (int i = 0; i < N; i++) begin
        rem_r[i] <= rem_nxt[i];
        rq_r[i]  <= rq_nxt[i];
      end
      for (int i = 1; i < N; i++) begin
        dvs_r[i]  <= dvs_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign quotient = rq_r[N-1];
  assign side_out = side_r[N-1];

endmodule

### sv/synapse_facdep_update_top.sv
// Top level of the facilitation/depression synapse record updater.
//
// One synapse record enters per in_ transaction and one updated record leaves
// per out_ transaction, in order. in_tuser carries {has_update, has_fired},
// in_tlast the last-in-group marker, which comes back on out_tlast; out_tuser
// carries the update-valid flag. Registers are written on the cfg_ channel,
// which is always ready; write them only while no record is in flight.
// The path from input to output transaction is set by the 64-stage quotient
// pipeline of the weight division and the exponential pipeline
// (EXP_TABLE_BITS + 5 stages) ahead of it.
// Throughput is one record per cycle while the receiver does not stall the output.
// A synchronous low rst_n empties the pipeline and loads register defaults:
// mode 1, increment 13107, scales 1.0, decay rates 0, window 1.
// When the receiver holds out_tready low with a result waiting, every stage
// holds and in_tready drops until the result is taken; nothing is lost.
module synapse_facdep_update_top #(
  parameter int EXP_TABLE_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // spike_step, last_update_step, weight_in, factor_a_in, factor_b_in, current_step
  input  logic [sfd_pkg::IN_DATA_W-1:0]   in_tdata,
  // has_fired, has_update
  input  logic [1:0]                      in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // weight_out, factor_a_out, factor_b_out, update_step_out
  output logic [sfd_pkg::OUT_DATA_W-1:0]  out_tdata,
  // update_valid_out
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import sfd_pkg::*;

  localparam int EXP_LAT = EXP_TABLE_BITS + 5;

  typedef struct packed {
    logic        do_upd;
    logic        pzero;
    logic [31:0] upd;
    logic        uv;
    logic        fin;
    logic [48:0] pold;
    logic [31:0] ah;
    logic [17:0] bh;
    logic [31:0] w;
    logic [31:0] a;
    logic [16:0] b;
  } exp_side_t;

  // configuration
  logic [1:0]  rule_mode_r;
  logic [31:0] fac_inc_r;
  logic [16:0] dep1_scale_r, dep2_scale_r;
  logic [23:0] fac_rate_r, dep1_rate_r, dep2_rate_r;
  logic [15:0] window_r;

  logic en;
  logic is_fac;

  // stage 1: input register
  logic        v1_r;
  logic [31:0] spike1_r, last1_r, w1_r, a1_r, now1_r;
  logic [16:0] b1_r;
  logic        fired1_r, hupd1_r, fin1_r;

  // stage 2
  logic        v2_r, do2_r, uv2_r, fin2_r, hit2_r;
  logic [31:0] upd2_r, w2_r, a2_r;
  logic [16:0] b2_r;
  logic [EL_W-1:0] el2_r;
  logic [48:0] pold2_r, sa2_r;
  logic [33:0] sb2_r;
  logic [32:0] fa2_r;

  // stage 3
  logic        v3_r;
  exp_side_t   s3_r;
  logic [EL_W-1:0] el3_r;

  // exponential alignment
  logic [EXP_LAT-1:0] ev_r;
  exp_side_t   ed_r [EXP_LAT];
  logic [32:0] ea, eb;

  // stages 4 to 6
  logic        v4_r, aup4_r, bup4_r;
  exp_side_t   s4_r;
  logic [31:0] ta4_r;
  logic [17:0] tb4_r;
  logic        v5_r;
  exp_side_t   s5_r;
  logic [31:0] ao5_r;
  logic [16:0] bo5_r;
  logic        v6_r;
  div_side_t   s6_r;
  logic [48:0] pold6_r;

  // divider output and final stages
  logic        dv_vld;
  logic [63:0] dq;
  div_side_t   dside;
  logic        v7_r;
  div_side_t   s7_r;
  logic [63:0] pp0_r, pp2_r;
  logic [48:0] pp1_r, pp3_r;

  logic        out_valid_r;
  logic [31:0] wo_r, ao_r, upd_o_r;
  logic [16:0] bo_r;
  logic        uv_o_r, fin_o_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign is_fac    = (rule_mode_r == MODE_FAC_DEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_mode_r  <= MODE_FAC_DEP;
      fac_inc_r    <= 32'd13107;
      dep1_scale_r <= 17'd65536;
      dep2_scale_r <= 17'd65536;
      fac_rate_r   <= '0;
      dep1_rate_r  <= '0;
      dep2_rate_r  <= '0;
      window_r     <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RULE_MODE:  rule_mode_r  <= cfg_data[1:0];
        REG_FAC_INC:    fac_inc_r    <= cfg_data;
        REG_DEP1_SCALE: dep1_scale_r <= cfg_data[16:0];
        REG_DEP2_SCALE: dep2_scale_r <= cfg_data[16:0];
        REG_FAC_RATE:   fac_rate_r   <= cfg_data[23:0];
        REG_DEP1_RATE:  dep1_rate_r  <= cfg_data[23:0];
        REG_DEP2_RATE:  dep2_rate_r  <= cfg_data[23:0];
        REG_WINDOW:     window_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 2 logic ----------------
  logic        active, do_upd, uv_c, hit;
  logic [31:0] upd_c, diff;
  logic [EL_W-1:0] el_c;
  logic [16:0] scale_b;

  always_comb begin
    active = ((rule_mode_r == MODE_FAC_DEP) || (rule_mode_r == MODE_DEP_DEP)) && fired1_r;
    do_upd = active && hupd1_r;
    uv_c   = active ? 1'b1 : hupd1_r;
    if (!active) begin
      upd_c = last1_r;
    end else if (!hupd1_r) begin
      upd_c = spike1_r;
    end else begin
      upd_c = now1_r;
    end
    diff = now1_r - last1_r;
    if (now1_r < last1_r) begin
      el_c = '0;
    end else if (diff > MAX_ELAPSED) begin
      el_c = EL_W'(MAX_ELAPSED);
    end else begin
      el_c = diff[EL_W-1:0];
    end
    hit = (now1_r >= spike1_r) &&
          ({1'b0, now1_r} < ({1'b0, spike1_r} + 33'(window_r)));
    scale_b = is_fac ? dep1_scale_r : dep2_scale_r;
  end

  // ---------------- stage 3 logic ----------------
  logic [49:0] sa_rnd;
  logic [34:0] sb_rnd;
  logic [31:0] fa_sat, sa_sat, ah_c;
  logic [17:0] bh_c;

  always_comb begin
    sa_rnd = 50'(sa2_r) + 50'd32768;
    sb_rnd = 35'(sb2_r) + 35'd32768;
    fa_sat = fa2_r[32] ? SAT32 : fa2_r[31:0];
    sa_sat = (|sa_rnd[49:48]) ? SAT32 : sa_rnd[47:16];
    ah_c   = hit2_r ? (is_fac ? fa_sat : sa_sat) : a2_r;
    bh_c   = hit2_r ? sb_rnd[33:16] : 18'(b2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ev_r <= '0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ev_r <= {ev_r[EXP_LAT-2:0], v3_r};
      v4_r <= ev_r[EXP_LAT-1];
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= dv_vld;
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // input capture
      spike1_r <= in_tdata[31:0];
      last1_r  <= in_tdata[63:32];
      w1_r     <= in_tdata[95:64];
      a1_r     <= in_tdata[127:96];
      b1_r     <= in_tdata[144:128];
      now1_r   <= in_tdata[176:145];
      fired1_r <= in_tuser[0];
      hupd1_r  <= in_tuser[1];
      fin1_r   <= in_tlast;
      // stage 2
      do2_r   <= do_upd;
      uv2_r   <= uv_c;
      upd2_r  <= upd_c;
      fin2_r  <= fin1_r;
      hit2_r  <= hit;
      el2_r   <= el_c;
      pold2_r <= 49'(a1_r) * 49'(b1_r);
      sa2_r   <= 49'(a1_r) * 49'(dep1_scale_r);
      sb2_r   <= 34'(b1_r) * 34'(scale_b);
      fa2_r   <= 33'(a1_r) + 33'(fac_inc_r);
      w2_r    <= w1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      // stage 3
      s3_r.do_upd <= do2_r;
      s3_r.pzero  <= (pold2_r == '0);
      s3_r.upd    <= upd2_r;
      s3_r.uv     <= uv2_r;
      s3_r.fin    <= fin2_r;
      s3_r.pold   <= pold2_r;
      s3_r.ah     <= ah_c;
      s3_r.bh     <= bh_c;
      s3_r.w      <= w2_r;
      s3_r.a      <= a2_r;
      s3_r.b      <= b2_r;
      el3_r       <= el2_r;
      // hold the record beside the exponential pipeline
      ed_r[0] <= s3_r;
      for (int i = 1; i < EXP_LAT; i++) begin
        ed_r[i] <= ed_r[i-1];
      end
    end
  end

  sfd_exp #(.TBITS(EXP_TABLE_BITS)) u_exp_a (
    .clk     (clk),
    .en      (en),
    .elapsed (el3_r),
    .rate    (is_fac ? fac_rate_r : dep1_rate_r),
    .e_out   (ea)
  );

  sfd_exp #(.TBITS(EXP_TABLE_BITS)) u_exp_b (
    .clk     (clk),
    .en      (en),
    .elapsed (el3_r),
    .rate    (is_fac ? dep1_rate_r : dep2_rate_r),
    .e_out   (eb)
  );

  // ---------------- decay toward 1.0 ----------------
  logic        aup, bup;
  logic [31:0] da;
  logic [17:0] db;
  logic [64:0] pa;
  logic [50:0] pb;
  logic [17:0] bo18;

  always_comb begin
    aup  = (ed_r[EXP_LAT-1].ah >= ONE_Q16);
    bup  = (ed_r[EXP_LAT-1].bh >= 18'(ONE_Q16));
    da   = aup ? (ed_r[EXP_LAT-1].ah - ONE_Q16) : (ONE_Q16 - ed_r[EXP_LAT-1].ah);
    db   = bup ? (ed_r[EXP_LAT-1].bh - 18'(ONE_Q16)) : (18'(ONE_Q16) - ed_r[EXP_LAT-1].bh);
    pa   = 65'(da) * 65'(ea);
    pb   = 51'(db) * 51'(eb);
    bo18 = bup4_r ? (18'(ONE_Q16) + tb4_r) : (18'(ONE_Q16) - tb4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r   <= ed_r[EXP_LAT-1];
      aup4_r <= aup;
      bup4_r <= bup;
      ta4_r  <= pa[63:32];
      tb4_r  <= pb[49:32];
      // stage 5
      s5_r  <= s4_r;
      ao5_r <= aup4_r ? (ONE_Q16 + ta4_r) : (ONE_Q16 - ta4_r);
      bo5_r <= bo18[17] ? SAT17 : bo18[16:0];
      // stage 6: new factor product, record into the divider
      s6_r.do_upd <= s5_r.do_upd;
      s6_r.pzero  <= s5_r.pzero;
      s6_r.ao     <= ao5_r;
      s6_r.bo     <= bo5_r;
      s6_r.prod   <= 49'(ao5_r) * 49'(bo5_r);
      s6_r.w      <= s5_r.w;
      s6_r.a      <= s5_r.a;
      s6_r.b      <= s5_r.b;
      s6_r.upd    <= s5_r.upd;
      s6_r.uv     <= s5_r.uv;
      s6_r.fin    <= s5_r.fin;
      pold6_r     <= s5_r.pold;
    end
  end

  sfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v6_r),
    .dividend ({s6_r.w, 32'd0}),
    .divisor  (pold6_r),
    .side_in  (s6_r),
    .out_vld  (dv_vld),
    .quotient (dq),
    .side_out (dside)
  );

  // ---------------- weight rebuild ----------------
  logic        wsat;
  logic [64:0] p0r;
  logic [33:0] wsum;
  logic [31:0] ws, wfinal;

  always_comb begin
    p0r    = 65'(pp0_r) + 65'h8000_0000;
    wsum   = 34'(pp1_r[31:0]) + 34'(pp2_r[31:0]) + 34'(p0r[64:32]);
    wsat   = (pp3_r != '0) || (pp1_r[48:32] != '0) || (pp2_r[63:32] != '0) ||
             (wsum > 34'(SAT32));
    ws     = wsat ? SAT32 : wsum[31:0];
    wfinal = s7_r.pzero ? SAT32 : ws;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r  <= dside;
      pp0_r <= 64'(dq[31:0]) * 64'(dside.prod[31:0]);
      pp1_r <= 49'(dq[31:0]) * 49'(dside.prod[48:32]);
      pp2_r <= 64'(dq[63:32]) * 64'(dside.prod[31:0]);
      pp3_r <= 49'(dq[63:32]) * 49'(dside.prod[48:32]);
      // output register
      wo_r    <= s7_r.do_upd ? wfinal : s7_r.w;
      ao_r    <= s7_r.do_upd ? s7_r.ao : s7_r.a;
      bo_r    <= s7_r.do_upd ? s7_r.bo : s7_r.b;
      upd_o_r <= s7_r.upd;
      uv_o_r  <= s7_r.uv;
      fin_o_r <= s7_r.fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, upd_o_r, bo_r, ao_r, wo_r};
  assign out_tuser  = uv_o_r;
  assign out_tlast  = fin_o_r;

endmodule

### sv/sfd_checker.sv
// Port-level checks of the synapse updater, bound to the top level.
module sfd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sfd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output transaction changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

endmodule

bind synapse_facdep_update_top sfd_checker u_sfd_checker (.*);
